>>> rtl/rtu_frame_receiver_assert.svh
// Assertion macros for the frame receiver RTL.
// Depends on nothing; included by rtu_frame_receiver, the module that carries assertions.
`ifndef RTU_FRAME_RECEIVER_ASSERT_SVH
`define RTU_FRAME_RECEIVER_ASSERT_SVH
`ifndef ASSERT_OFF
// Property checked on every rising clock edge, suspended while reset is asserted.
`define RTU_ASSERT(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Condition that must never be true on a rising clock edge outside reset.
`define RTU_NEVER(lbl, clk, rstn, cond, msg) \
	`RTU_ASSERT(lbl, clk, rstn, !(cond), msg)
`else
`define RTU_ASSERT(lbl, clk, rstn, prop, msg)
`define RTU_NEVER(lbl, clk, rstn, cond, msg)
`endif
`endif

>>> rtl/rtu_pkg.sv
// Package of the frame receiver: widths, codes, reset values and the CRC step function.
// Depends on nothing; used by the interfaces, rtu_crc_unit and rtu_frame_receiver.
package rtu_pkg;

	localparam int STORE_DEPTH = 64;
	localparam int ADDR_W = $clog2(STORE_DEPTH);
	localparam int WPOS_W = ADDR_W + 1;
	localparam int STORE_BASE = 3;
	localparam int CRC_TAIL = 2;

	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 16;
	localparam logic [CFG_IDX_W-1:0] REG_LOCAL_ADDRESS = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT_TICKS = 2'd1;
	localparam logic [7:0] ADDR_RESET = 8'd1;
	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	localparam int ELAPSED_W = 17;
	localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

	localparam logic OP_BYTE = 1'b0;
	localparam logic OP_TICK = 1'b1;

	localparam logic [1:0] STATUS_GOOD = 2'd0;
	localparam logic [1:0] STATUS_CRC = 2'd1;
	localparam logic [1:0] STATUS_LONG = 2'd2;

	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam int CRC_STEPS = 8;
	localparam int CRC_CNT_W = $clog2(CRC_STEPS + 1);

	typedef struct packed {
		logic start;
		logic seed;
		logic [7:0] data;
	} crc_cmd_t;

	typedef struct packed {
		logic busy;
		logic [15:0] crc;
	} crc_stat_t;

	// One bit of the reflected CRC-16 shift.
	function automatic logic [15:0] crc_bit_step(input logic [15:0] crc);
		crc_bit_step = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
	endfunction

endpackage

>>> rtl/rtu_if.sv
// Valid/ready channel interfaces of the frame receiver: input items, results, configuration.
// Depends on rtu_pkg.
interface rtu_item_if import rtu_pkg::*; ();
	logic valid;
	logic ready;
	logic op;
	logic [7:0] byte_value;

	modport source(output valid, op, byte_value, input ready);
	modport sink(input valid, op, byte_value, output ready);
endinterface

interface rtu_result_if import rtu_pkg::*; ();
	logic valid;
	logic ready;
	logic [1:0] status;
	logic [7:0] func_code;
	logic [7:0] data_length;
	logic has_byte;
	logic [7:0] payload_byte;
	logic [5:0] byte_index;
	logic last;

	modport source(output valid, status, func_code, data_length, has_byte, payload_byte,
		byte_index, last, input ready);
	modport sink(input valid, status, func_code, data_length, has_byte, payload_byte,
		byte_index, last, output ready);
endinterface

interface rtu_cfg_if import rtu_pkg::*; ();
	logic valid;
	logic ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

>>> rtl/rtu_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module rtu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/rtu_crc_unit.sv
// Bit-serial CRC-16 unit: folds in one byte, then shifts one bit per cycle.
// Depends on rtu_pkg.
module rtu_crc_unit import rtu_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  crc_cmd_t  cmd,
	output crc_stat_t stat
);

	logic [15:0] crc_q;
	logic [CRC_CNT_W-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
			cnt_q <= '0;
		end else if (cmd.start) begin
			crc_q <= (cmd.seed ? CRC_INIT : crc_q) ^ {8'h00, cmd.data};
			cnt_q <= CRC_CNT_W'(CRC_STEPS);
		end else if (cnt_q != '0) begin
			crc_q <= crc_bit_step(crc_q);
			cnt_q <= cnt_q - 1'b1;
		end
	end

	assign stat.busy = (cnt_q != '0);
	assign stat.crc = crc_q;

endmodule

>>> rtl/rtu_frame_receiver.sv
// Top level of the frame receiver: parse sequencer, timeout counter, result register.
// Depends on rtu_pkg, rtu_if, rtu_ram, rtu_crc_unit and rtu_frame_receiver_assert.svh.
//
// Each request is one received byte or one time tick. A tick does not hold the input off.
// A byte that enters the CRC (address match, function code, length, payload) is taken and
// then holds the input off while the bit-serial CRC unit shifts one bit per cycle; the two
// CRC bytes and ignored bytes do not hold the input off. A status result holds the input off
// until it is loaded into the result register. Payload of a good frame is read back from
// the 64-byte frame store, each result passing through ST_EMIT_WAIT for the registered read
// of the store and then ST_EMIT_DATA; the input is held off during that burst. A waiting
// result does not stall the input unless a new result is due. The frame store needs no
// clearing after reset.
`include "rtu_frame_receiver_assert.svh"

module rtu_frame_receiver import rtu_pkg::*; (
	input logic            clk,
	input logic            arst_n,
	rtu_item_if.sink       item,
	rtu_result_if.source   result,
	rtu_cfg_if.sink        cfg
);

	localparam int POS_W = 9;

	localparam logic [1:0] STEP_HUNT = 2'd0;
	localparam logic [1:0] STEP_CODE = 2'd1;
	localparam logic [1:0] STEP_LEN  = 2'd2;
	localparam logic [1:0] STEP_BODY = 2'd3;

	localparam logic [1:0] ST_IDLE      = 2'd0;
	localparam logic [1:0] ST_STATUS    = 2'd1;
	localparam logic [1:0] ST_EMIT_WAIT = 2'd2;
	localparam logic [1:0] ST_EMIT_DATA = 2'd3;

	logic [1:0] state_q;
	logic [1:0] step_q;
	logic [WPOS_W-1:0] wp_q;
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [7:0] local_addr_q;
	logic [15:0] timeout_q;
	logic [ADDR_W-1:0] emit_idx_q;
	logic [7:0] code_q;
	logic [7:0] len_q;
	logic [7:0] crc_lo_q;
	logic [1:0] status_q;
	logic out_valid_q;

	crc_cmd_t crc_cmd;
	crc_stat_t crc_stat;
	logic ram_we;
	logic [7:0] ram_rdata;
	logic [ADDR_W-1:0] ram_raddr;

	logic acc;
	logic is_byte;
	logic body_full;
	logic [WPOS_W-1:0] wp_inc;
	logic is_final;
	logic in_payload;
	logic crc_ok;
	logic [ELAPSED_W-1:0] elapsed_inc;
	logic timed_out;
	logic slot_free;
	logic emit_last;
	logic load_status;
	logic load_byte;

	assign item.ready = (state_q == ST_IDLE) && !crc_stat.busy;
	assign cfg.ready = 1'b1;

	assign acc = item.valid && item.ready;
	assign is_byte = (item.op == OP_BYTE);
	assign body_full = (wp_q >= WPOS_W'(STORE_DEPTH));
	assign wp_inc = wp_q + 1'b1;
	assign is_final = (POS_W'(wp_inc) >= (POS_W'(len_q) + POS_W'(STORE_BASE + CRC_TAIL)));
	assign in_payload = (POS_W'(wp_q) < (POS_W'(len_q) + POS_W'(STORE_BASE)));
	// The CRC arrives low byte first; the high byte is the one being taken now.
	assign crc_ok = ({item.byte_value, crc_lo_q} == crc_stat.crc);
	assign elapsed_inc = (elapsed_q == ELAPSED_MAX) ? elapsed_q : (elapsed_q + 1'b1);
	assign timed_out = (elapsed_inc > ELAPSED_W'(timeout_q));

	assign slot_free = !out_valid_q || result.ready;
	assign emit_last = ((8'(emit_idx_q) + 8'd1) == len_q);
	assign load_status = (state_q == ST_STATUS) && slot_free;
	assign load_byte = (state_q == ST_EMIT_DATA) && slot_free;

	always_comb begin
		crc_cmd.seed = (step_q == STEP_HUNT);
		crc_cmd.data = item.byte_value;
		crc_cmd.start = 1'b0;
		if (acc && is_byte) begin
			unique case (step_q)
				STEP_HUNT: crc_cmd.start = (item.byte_value == local_addr_q);
				STEP_CODE: crc_cmd.start = 1'b1;
				STEP_LEN:  crc_cmd.start = 1'b1;
				STEP_BODY: crc_cmd.start = !body_full && in_payload;
				default:   crc_cmd.start = 1'b0;
			endcase
		end
	end

	assign ram_we = acc && is_byte && (step_q == STEP_BODY) && !body_full;
	assign ram_raddr = ADDR_W'(STORE_BASE) + emit_idx_q;

	rtu_crc_unit u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (crc_cmd),
		.stat   (crc_stat)
	);

	rtu_ram #(
		.WIDTH (8),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (wp_q[ADDR_W-1:0]),
		.wdata (item.byte_value),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= STEP_HUNT;
			wp_q <= WPOS_W'(STORE_BASE);
			elapsed_q <= '0;
			local_addr_q <= ADDR_RESET;
			timeout_q <= TIMEOUT_RESET;
			emit_idx_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_LOCAL_ADDRESS) begin
					local_addr_q <= cfg.data[7:0];
				end else if (cfg.index == REG_TIMEOUT_TICKS) begin
					timeout_q <= cfg.data;
				end
			end
			if (load_status || load_byte) begin
				out_valid_q <= 1'b1;
			end else if (result.valid && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (acc && !is_byte) begin
						if (step_q != STEP_HUNT) begin
							elapsed_q <= elapsed_inc;
							if (timed_out) begin
								step_q <= STEP_HUNT;
								wp_q <= WPOS_W'(STORE_BASE);
							end
						end
					end else if (acc) begin
						unique case (step_q)
							STEP_HUNT: begin
								if (item.byte_value == local_addr_q) begin
									elapsed_q <= '0;
									step_q <= STEP_CODE;
								end
							end
							STEP_CODE: step_q <= STEP_LEN;
							STEP_LEN: begin
								wp_q <= WPOS_W'(STORE_BASE);
								step_q <= STEP_BODY;
							end
							STEP_BODY: begin
								if (body_full) begin
									state_q <= ST_STATUS;
									step_q <= STEP_HUNT;
									wp_q <= WPOS_W'(STORE_BASE);
								end else if (is_final) begin
									step_q <= STEP_HUNT;
									wp_q <= WPOS_W'(STORE_BASE);
									if (crc_ok && (len_q != 8'd0)) begin
										emit_idx_q <= '0;
										state_q <= ST_EMIT_WAIT;
									end else begin
										state_q <= ST_STATUS;
									end
								end else begin
									wp_q <= wp_inc;
								end
							end
							default: step_q <= STEP_HUNT;
						endcase
					end
				end
				ST_STATUS: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_EMIT_WAIT: state_q <= ST_EMIT_DATA;
				ST_EMIT_DATA: begin
					if (slot_free) begin
						if (emit_last) begin
							state_q <= ST_IDLE;
						end else begin
							emit_idx_q <= emit_idx_q + 1'b1;
							state_q <= ST_EMIT_WAIT;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Frame fields, the pending status and the result payload need no reset.
	always_ff @(posedge clk) begin
		if (acc && is_byte) begin
			if (step_q == STEP_CODE) begin
				code_q <= item.byte_value;
			end
			if (step_q == STEP_LEN) begin
				len_q <= item.byte_value;
			end
			if (step_q == STEP_BODY) begin
				crc_lo_q <= item.byte_value;
				if (body_full) begin
					status_q <= STATUS_LONG;
				end else if (!crc_ok) begin
					status_q <= STATUS_CRC;
				end else begin
					status_q <= STATUS_GOOD;
				end
			end
		end
		if (load_status) begin
			result.status <= status_q;
			result.func_code <= code_q;
			result.data_length <= len_q;
			result.has_byte <= 1'b0;
			result.payload_byte <= 8'd0;
			result.byte_index <= 6'd0;
			result.last <= 1'b1;
		end else if (load_byte) begin
			result.status <= STATUS_GOOD;
			result.func_code <= code_q;
			result.data_length <= len_q;
			result.has_byte <= 1'b1;
			result.payload_byte <= ram_rdata;
			result.byte_index <= 6'(emit_idx_q);
			result.last <= emit_last;
		end
	end

	assign result.valid = out_valid_q;

	`RTU_NEVER(a_ready_while_crc, clk, arst_n, item.ready && crc_stat.busy, "input ready while CRC unit busy")
	`RTU_NEVER(a_wp_range, clk, arst_n, wp_q > WPOS_W'(STORE_DEPTH), "write position past store")
	`RTU_NEVER(a_wp_outside_body, clk, arst_n, (step_q != STEP_BODY) && (wp_q != WPOS_W'(STORE_BASE)), "write position moved outside frame body")
	`RTU_ASSERT(a_tick_no_result, clk, arst_n, (acc && (item.op == OP_TICK)) |=> !$rose(result.valid), "tick request produced a result")

endmodule
